// ===== rtl/core/epw_pkg.sv =====
// Shared types and constants for the entropy pool whitener.
package epw_pkg;

    // Multiplier constants for the pool fold and the output finalizer.
    localparam logic [63:0] FOLD_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] FIN_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] FIN_MUL_B = 64'h94D0_49BB_1331_11EB;

    // Shift and rotate amounts.
    localparam int unsigned FOLD_ROT  = 31;
    localparam int unsigned FIN_SH_A  = 30;
    localparam int unsigned FIN_SH_B  = 27;
    localparam int unsigned FIN_SH_C  = 31;

    // Words-per-output register.
    localparam int unsigned WPO_W     = 4;
    localparam logic [WPO_W-1:0] WPO_RESET = 4'd4;
    localparam logic [WPO_W-1:0] WPO_MIN   = 4'd1;
    localparam logic [WPO_W-1:0] WPO_MAX   = 4'd8;

    // Input transfer payload.
    typedef struct packed {
        logic [31:0] raw_word;
        logic        source_fault;
    } in_item_t;

    // Result transfer payload.
    typedef struct packed {
        logic [31:0] random_word;
        logic        generator_ok;
    } out_item_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // Response from the shared multiplier.
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

endpackage

// ===== rtl/core/epw_mul64.sv =====
// Iterative 64x64 multiplier (low 64 bits) built on one 32x32 multiplier.
module epw_mul64 (
    input  logic              aclk,
    input  logic              aresetn,
    input  epw_pkg::mul_req_t req,
    output epw_pkg::mul_rsp_t rsp
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;

    // Pick the operand halves for this step: lo*lo, lo*hi, hi*lo.
    always_comb begin
        case (step_reg)
            2'd0: begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1: begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default: begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
    end

    // The one 32x32 multiplier, registered before any accumulation.
    assign prod_next = {32'h0, op_x} * {32'h0, op_y};

    // Fold the previous step's product into the accumulator.
    always_comb begin
        if (step_reg == 2'd1) begin
            acc_next = prod_reg;
        end else begin
            acc_next = acc_reg + {prod_reg[31:0], 32'h0};
        end
    end

    // Operand and datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            if (step_reg != 2'd0) begin
                acc_reg <= acc_next;
            end
        end
    end

    // Step sequencing and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/core/entropy_pool_whitener.sv =====
// Top level of the entropy pool whitener: pool fold, finalizer and handshakes.
//
// Raw noise words arrive on the s_ channel (valid/ready) and whitened words
// leave on the m_ channel (valid/ready). Each raw word is folded into a
// 64-bit pool; after words_per_output folds (set through cfg_wr_en and
// cfg_wr_data, 0 acts as 1 and values above 8 act as 8) the pool is run
// through the splitmix64 finalizer and its low 32 bits are emitted with a
// health flag that drops for good once any faulty word has been seen.
// All 64-bit products come from one shared 32x32 multiplier, so s_ready
// stays low while a word is folded, and a word that emits also waits for
// both finalizer products before its result is presented on m_valid. A new
// raw word is taken while the previous result still waits in the output
// register; if the receiver stalls longer, the next result waits inside the
// block and s_ready stays low until the output register frees up. Reset
// clears the pool, the fold count, the fault latch and the output valid
// flag, and loads four into words_per_output.
module entropy_pool_whitener (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  epw_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output epw_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [epw_pkg::WPO_W-1:0]       cfg_wr_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FOLD = 5'b00010,
        S_FINA = 5'b00100,
        S_FINB = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [63:0]                 pool_reg;
    logic [2:0]                  fold_count_reg;
    logic                        fault_latch_reg;
    logic                        emit_reg;
    logic [epw_pkg::WPO_W-1:0]   wpo_reg;
    logic [31:0]                 fin_reg;
    logic                        m_valid_reg;
    epw_pkg::out_item_t          m_data_reg;

    logic                        in_xfer;
    logic                        out_free;
    logic [31:0]                 word_eff;
    logic [epw_pkg::WPO_W-1:0]   limit;
    logic [3:0]                  done_cnt;
    logic                        emit_now;
    logic [63:0]                 rot;
    logic [63:0]                 mix_a;
    logic [63:0]                 mix_b;
    logic [63:0]                 mix_c;
    epw_pkg::mul_req_t           mul_req;
    epw_pkg::mul_rsp_t           mul_rsp;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Clamp the configured batch size and decide whether this word emits.
    always_comb begin
        if (wpo_reg < epw_pkg::WPO_MIN) begin
            limit = epw_pkg::WPO_MIN;
        end else if (wpo_reg > epw_pkg::WPO_MAX) begin
            limit = epw_pkg::WPO_MAX;
        end else begin
            limit = wpo_reg;
        end
    end

    assign done_cnt = {1'b0, fold_count_reg} + 4'd1;
    assign emit_now = (done_cnt >= limit);
    assign word_eff = s_data.source_fault ? 32'h0 : s_data.raw_word;

    // Post-multiply mixing steps: rotate after the fold, xor-shifts around
    // the two finalizer products.
    assign rot   = {mul_rsp.product[63-epw_pkg::FOLD_ROT:0],
                    mul_rsp.product[63:64-epw_pkg::FOLD_ROT]};
    assign mix_a = rot ^ (rot >> epw_pkg::FIN_SH_A);
    assign mix_b = mul_rsp.product ^ (mul_rsp.product >> epw_pkg::FIN_SH_B);
    assign mix_c = mul_rsp.product ^ (mul_rsp.product >> epw_pkg::FIN_SH_C);

    // Requests to the shared multiplier.
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = pool_reg ^ {32'h0, word_eff};
        mul_req.b     = epw_pkg::FOLD_MUL;
        if (in_xfer) begin
            mul_req.start = 1'b1;
        end else if ((state_reg == S_FOLD) && mul_rsp.done && emit_reg) begin
            mul_req.start = 1'b1;
            mul_req.a     = mix_a;
            mul_req.b     = epw_pkg::FIN_MUL_A;
        end else if ((state_reg == S_FINA) && mul_rsp.done) begin
            mul_req.start = 1'b1;
            mul_req.a     = mix_b;
            mul_req.b     = epw_pkg::FIN_MUL_B;
        end
    end

    epw_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                if (mul_rsp.done) begin
                    state_next = emit_reg ? S_FINA : S_IDLE;
                end
            end
            S_FINA: begin
                if (mul_rsp.done) begin
                    state_next = S_FINB;
                end
            end
            S_FINB: begin
                if (mul_rsp.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, pool and configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pool_reg        <= 64'h0;
            fold_count_reg  <= 3'd0;
            fault_latch_reg <= 1'b0;
            emit_reg        <= 1'b0;
            wpo_reg         <= epw_pkg::WPO_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                wpo_reg <= cfg_wr_data;
            end
            if (in_xfer) begin
                emit_reg       <= emit_now;
                fold_count_reg <= emit_now ? 3'd0 : done_cnt[2:0];
                if (s_data.source_fault) begin
                    fault_latch_reg <= 1'b1;
                end
            end
            if ((state_reg == S_FOLD) && mul_rsp.done) begin
                pool_reg <= rot;
            end
            if ((state_reg == S_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Finalized word and output register payload.
    always_ff @(posedge aclk) begin
        if ((state_reg == S_FINB) && mul_rsp.done) begin
            fin_reg <= mix_c[31:0];
        end
        if ((state_reg == S_EMIT) && out_free) begin
            m_data_reg.random_word  <= fin_reg;
            m_data_reg.generator_ok <= !fault_latch_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // The multiplier only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == S_FOLD || state_reg == S_FINA ||
                          state_reg == S_FINB))
        else $error("multiplier finished outside a wait state");

    // An accepted word always starts a fold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == S_FOLD))
        else $error("accepted word did not start a fold");

    // The fault latch never clears outside reset.
    assert property (@(posedge aclk)
        (aresetn && $past(aresetn) && $past(fault_latch_reg)) |-> fault_latch_reg)
        else $error("fault latch cleared without reset");
`endif

endmodule
